[rtl/core/mnbr_pkg.sv]
// Shared types, constants and codes for the Moore neighbor enumerator.
package mnbr_pkg;

  localparam int IDX_W        = 30;   // linear voxel index width
  localparam int CFG_W        = 11;   // widest configuration register
  localparam int CFG_IDX_W    = 2;    // register index width
  localparam int NUM_OFFSETS  = 27;   // 3x3x3 offset cube
  localparam int CENTER       = 13;   // offset (0,0,0), never emitted
  localparam int MAX_SIDE_DEF = 1024;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET       = CFG_W'(64);
  localparam logic             THREE_DIMS_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THREE_DIMS = 2'd0,
    REG_SIZE_X     = 2'd1,
    REG_SIZE_Y     = 2'd2,
    REG_SIZE_Z     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PLANE,
    F_TOTAL,
    F_CHECK,
    F_DIVZ,
    F_DIVY,
    F_PUSH
  } front_state_t;

  // One classified voxel: its index, the plane stride (modulo 2^IDX_W)
  // and one bit per in-grid neighbor offset. An all-zero mask is empty.
  typedef struct packed {
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       plane;
    logic [NUM_OFFSETS-1:0] mask;
  } nbr_entry_t;

endpackage

[rtl/core/mnbr_front.sv]
// Front end: accepts a voxel index, splits it into coordinates, builds the neighbor mask.
module mnbr_front
  import mnbr_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [IDX_W-1:0]                  voxel_index,
  input  logic [$clog2(MAX_SIDE+1)-1:0]     nx,
  input  logic [$clog2(MAX_SIDE+1)-1:0]     ny,
  input  logic [$clog2(MAX_SIDE+1)-1:0]     nz,
  output logic                              push_valid,
  output nbr_entry_t                        push_entry,
  input  logic                              queue_full
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int PLANE_W = 2 * SIDE_W;
  localparam int TOTAL_W = 3 * SIDE_W;
  localparam int DVS_W   = PLANE_W + COORD_W;
  localparam int CMP_W   = (DVS_W > IDX_W) ? DVS_W : IDX_W;
  localparam int TCMP_W  = (TOTAL_W > IDX_W) ? TOTAL_W : IDX_W;
  localparam int CNT_W   = $clog2(COORD_W) + 1;

  front_state_t         state, state_next;
  logic [IDX_W-1:0]     idx;
  logic [PLANE_W-1:0]   plane;
  logic [TOTAL_W-1:0]   total;
  logic [IDX_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [COORD_W-1:0]   quo;
  logic [CNT_W-1:0]     cnt;
  logic [COORD_W-1:0]   zc;
  logic [COORD_W-1:0]   yc;
  logic                 outside;

  logic                 ge;
  logic [IDX_W-1:0]     rem_next;
  logic [COORD_W-1:0]   quo_next;
  logic                 out_of_grid;
  logic [COORD_W-1:0]   xc;
  logic [2:0]           xok, yok, zok;
  logic [NUM_OFFSETS-1:0] mask;

  // Shared restoring divide step: one quotient bit per cycle.
  always_comb begin
    ge       = CMP_W'(rem) >= CMP_W'(dvs);
    rem_next = ge ? (rem - IDX_W'(dvs)) : rem;
    quo_next = COORD_W'({quo, ge});
  end

  assign out_of_grid = (total == '0) || (TCMP_W'(idx) >= TCMP_W'(total));

  // Neighbor mask from coordinates; bit k is offset (dz,dy,dx) with k = dz*9+dy*3+dx.
  always_comb begin
    xc     = COORD_W'(rem);
    xok[0] = (xc != '0);
    xok[1] = 1'b1;
    xok[2] = (SIDE_W'(xc) + SIDE_W'(1)) < nx;
    yok[0] = (yc != '0);
    yok[1] = 1'b1;
    yok[2] = (SIDE_W'(yc) + SIDE_W'(1)) < ny;
    zok[0] = (zc != '0);
    zok[1] = 1'b1;
    zok[2] = (SIDE_W'(zc) + SIDE_W'(1)) < nz;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          mask[dz*9 + dy*3 + dx] = zok[dz] & yok[dy] & xok[dx];
        end
      end
    end
    mask[CENTER] = 1'b0;
    if (outside) begin
      mask = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (in_valid) state_next = F_PLANE;
      F_PLANE: state_next = F_TOTAL;
      F_TOTAL: state_next = F_CHECK;
      F_CHECK: state_next = out_of_grid ? F_PUSH : F_DIVZ;
      F_DIVZ:  if (cnt == '0) state_next = F_DIVY;
      F_DIVY:  if (cnt == '0) state_next = F_PUSH;
      F_PUSH:  if (!queue_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = (state != F_IDLE);
    push_valid       = (state == F_PUSH);
    push_entry.idx   = idx;
    push_entry.plane = IDX_W'(plane);
    push_entry.mask  = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        idx <= voxel_index;
      end
      F_PLANE: begin
        plane <= PLANE_W'(nx) * PLANE_W'(ny);
      end
      F_TOTAL: begin
        total <= TOTAL_W'(plane) * TOTAL_W'(nz);
      end
      F_CHECK: begin
        outside <= out_of_grid;
        rem     <= idx;
        dvs     <= DVS_W'(plane) << (COORD_W - 1);
        quo     <= '0;
        cnt     <= CNT_W'(COORD_W - 1);
      end
      F_DIVZ: begin
        rem <= rem_next;
        if (cnt == '0) begin
          zc  <= quo_next;
          dvs <= DVS_W'(nx) << (COORD_W - 1);
          quo <= '0;
          cnt <= CNT_W'(COORD_W - 1);
        end else begin
          dvs <= dvs >> 1;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
        end
      end
      F_DIVY: begin
        rem <= rem_next;
        dvs <= dvs >> 1;
        quo <= quo_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          yc <= quo_next;
        end
      end
      default: begin
      end
    endcase
  end

  // The 2D case depends on the plane count of one: no z neighbor may appear.
  assert property (@(posedge clk) disable iff (rst)
    (push_valid && nz == SIDE_W'(1)) |->
      (push_entry.mask[8:0] == '0 && push_entry.mask[26:18] == '0))
    else $error("z neighbor produced for a single-plane grid");

endmodule

[rtl/core/mnbr_queue.sv]
// Short queue of classified voxels between the front and back ends.
module mnbr_queue
  import mnbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  nbr_entry_t  push_entry,
  output logic        full,
  output logic        pop_valid,
  output nbr_entry_t  pop_entry,
  input  logic        pop_take
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  nbr_entry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push_fire;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign push_fire = push_valid && !full;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_fire) - CNT_W'(pop_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop_take |-> pop_valid)
    else $error("queue popped while empty");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

[rtl/core/mnbr_back.sv]
// Back end: walks the neighbor mask in ascending order and emits one index per beat.
module mnbr_back
  import mnbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  nbr_entry_t        pop_entry,
  output logic              pop_take,
  input  logic [IDX_W-1:0]  row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  neighbor_index,
  output logic              last,
  output logic              empty_res
);

  logic                    cur_valid;
  logic [IDX_W-1:0]        cur_idx;
  logic [IDX_W-1:0]        cur_plane;
  logic [NUM_OFFSETS-1:0]  cur_mask;

  logic                    adv;
  logic                    emit;
  logic                    fin;
  logic [NUM_OFFSETS-1:0]  sel;
  logic [NUM_OFFSETS-1:0]  mask_left;
  logic                    dz_neg, dz_pos, dy_neg, dy_pos, dx_neg, dx_pos;
  logic [IDX_W-1:0]        zterm, yterm, xterm;
  logic [IDX_W-1:0]        nbr;

  always_comb begin
    adv       = !out_valid || !out_stall;
    emit      = cur_valid && adv;
    sel       = cur_mask & (~cur_mask + NUM_OFFSETS'(1));
    mask_left = cur_mask & ~sel;
    fin       = emit && (mask_left == '0);
    pop_take  = pop_valid && (!cur_valid || fin);
  end

  // Decode the chosen offset per axis from the one-hot pick.
  always_comb begin
    dz_neg = |sel[8:0];
    dz_pos = |sel[26:18];
    dy_neg = 1'b0;
    dy_pos = 1'b0;
    dx_neg = 1'b0;
    dx_pos = 1'b0;
    for (int dz = 0; dz < 3; dz++) begin
      for (int d = 0; d < 3; d++) begin
        dy_neg = dy_neg | sel[dz*9 + d];
        dy_pos = dy_pos | sel[dz*9 + 6 + d];
        dx_neg = dx_neg | sel[dz*9 + d*3];
        dx_pos = dx_pos | sel[dz*9 + d*3 + 2];
      end
    end
    zterm = dz_neg ? (~cur_plane + IDX_W'(1)) : (dz_pos ? cur_plane : '0);
    yterm = dy_neg ? (~row + IDX_W'(1)) : (dy_pos ? row : '0);
    xterm = dx_neg ? '1 : (dx_pos ? IDX_W'(1) : '0);
    nbr   = cur_idx + zterm + yterm + xterm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_take) begin
        cur_valid <= 1'b1;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (adv) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_take) begin
      cur_idx   <= pop_entry.idx;
      cur_plane <= pop_entry.plane;
      cur_mask  <= pop_entry.mask;
    end else if (emit) begin
      cur_mask <= mask_left;
    end
    if (emit) begin
      neighbor_index <= (cur_mask == '0) ? '0 : nbr;
      last           <= (mask_left == '0);
      empty_res      <= (cur_mask == '0);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (last && neighbor_index == '0))
    else $error("empty result not marked last or carries an index");

  assert property (@(posedge clk) disable iff (rst) cur_valid |-> !cur_mask[CENTER])
    else $error("voxel listed as its own neighbor");

  assert property (@(posedge clk) disable iff (rst)
    (emit && !fin) |=> (cur_valid && $countones(cur_mask) == $countones($past(mask_left))))
    else $error("neighbor walk lost its place");

endmodule

[rtl/core/moore_neighbor_enumerator_unit.sv]
// Top level of the Moore neighbor enumerator: config registers, front, queue, back.
//
// Usage: write three_dims, size_x, size_y, size_z through cfg_write/cfg_index/cfg_data
// while the block is idle. Each beat on the input channel (in_valid/in_stall) carries
// one linear voxel_index, x fastest. For each one the output channel (out_valid/out_stall)
// gives the in-grid Moore neighbors in ascending linear order, one beat each, the last
// beat marked by last. An index outside the grid, or a voxel without neighbors, gives
// one beat with empty_res and last set and neighbor_index zero. Sizes above MAX_SIDE
// saturate to MAX_SIDE; in 2D mode size_z is ignored.
// Flow: the front end captures the index, forms the plane and total sizes, checks the
// index against the grid, runs the shared one-bit-per-cycle divider to find z and then
// y, and pushes the entry; an index outside the grid skips the divider. The front takes
// a new index only after it has pushed the last one. The back end emits one neighbor per
// cycle while out_stall is low, up to 26 per voxel. A two-entry queue between them lets
// the front classify the next voxel while the back is still emitting, so sustained
// throughput is set by the slower of the two per voxel.
// Reset (rst, synchronous) restores the register defaults (3D, 64 per side) and empties
// the queue and output register. When the receiver stalls, the output beat holds and
// the back end waits; the queue then fills and in_stall stays high.
module moore_neighbor_enumerator_unit
  import mnbr_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IDX_W-1:0]      voxel_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      neighbor_index,
  output logic                  last,
  output logic                  empty_res
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic              three_dims;
  logic [CFG_W-1:0]  size_x;
  logic [CFG_W-1:0]  size_y;
  logic [CFG_W-1:0]  size_z;

  logic [SIDE_W-1:0] nx, ny, nz;
  logic [IDX_W-1:0]  row;

  logic              push_valid;
  nbr_entry_t        push_entry;
  logic              queue_full;
  logic              pop_valid;
  nbr_entry_t        pop_entry;
  logic              pop_take;

  // Configuration registers: plain write, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      three_dims <= THREE_DIMS_RESET;
      size_x     <= SIZE_RESET;
      size_y     <= SIZE_RESET;
      size_z     <= SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THREE_DIMS: three_dims <= cfg_data[0];
        REG_SIZE_X:     size_x     <= cfg_data;
        REG_SIZE_Y:     size_y     <= cfg_data;
        REG_SIZE_Z:     size_z     <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Saturate sides to MAX_SIDE; a 2D grid is one plane deep.
  always_comb begin
    nx = (int'(size_x) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(size_x);
    ny = (int'(size_y) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(size_y);
    if (!three_dims) begin
      nz = SIDE_W'(1);
    end else begin
      nz = (int'(size_z) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(size_z);
    end
    row = IDX_W'(nx);
  end

  mnbr_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .voxel_index (voxel_index),
    .nx          (nx),
    .ny          (ny),
    .nz          (nz),
    .push_valid  (push_valid),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  mnbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_take   (pop_take)
  );

  mnbr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_entry      (pop_entry),
    .pop_take       (pop_take),
    .row            (row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_index (neighbor_index),
    .last           (last),
    .empty_res      (empty_res)
  );

endmodule
